// File: hdl/bgi_pkg.sv
// ----------------------------------------------------------------------------
// bgi_pkg
// Shared types and constants of the bilinear grid interpolator: item codes,
// controller states, and the command and status words between controller
// and datapath.
// ----------------------------------------------------------------------------
package bgi_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_LOAD_G = 2'd2,
    OP_QUERY  = 2'd3
  } bgi_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RD_LO,
    ST_RD_HI,
    ST_DIFF,
    ST_GRD,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_ACC,
    ST_DMUL,
    ST_DCHK,
    ST_DIV,
    ST_RND,
    ST_FIN
  } bgi_state_t;

  // coordinate memory read address source
  typedef enum logic [1:0] {
    CRD_SCAN,
    CRD_LO,
    CRD_HI
  } bgi_crd_t;

  typedef struct packed {
    logic     load;
    logic     capture;
    logic     scan;
    bgi_crd_t crd;
    logic     cap_lo;
    logic     diff;
    logic     grd;
    logic     m1;
    logic     m2;
    logic     m3;
    logic     acc;
    logic     dmul;
    logic     dchk;
    logic     div;
    logic     rnd;
    logic     fin;
  } bgi_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic term_last;
    logic div_last;
    logic dzero;
  } bgi_sts_t;

  // numerator magnitude and accumulator width
  localparam int ACC_W     = 98;
  localparam int DIV_CNT_W = 7;

  localparam int          CFG_ADDR_W = 3;
  localparam logic        REG_X_USED = 1'b0;
  localparam logic        REG_Y_USED = 1'b1;
  localparam logic [6:0]  USED_RESET = 7'd64;

  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;

endpackage

// File: hdl/bgi_cfg.sv
// ----------------------------------------------------------------------------
// bgi_cfg
// APB register file holding the number of x and y grid points in use.
// ----------------------------------------------------------------------------
module bgi_cfg
  import bgi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [6:0]            x_used,
  output logic [6:0]            y_used
);

  logic [6:0] x_used_r, x_used_nxt;
  logic [6:0] y_used_r, y_used_nxt;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    x_used_nxt = x_used_r;
    y_used_nxt = y_used_r;
    if (wr) begin
      unique case (paddr[2])
        REG_X_USED: x_used_nxt = pwdata[6:0];
        REG_Y_USED: y_used_nxt = pwdata[6:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_used_r <= USED_RESET;
      y_used_r <= USED_RESET;
    end else begin
      x_used_r <= x_used_nxt;
      y_used_r <= y_used_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_Y_USED) ? {25'd0, y_used_r} : {25'd0, x_used_r};
  assign x_used = x_used_r;
  assign y_used = y_used_r;

endmodule

// File: hdl/bgi_ctrl.sv
// ----------------------------------------------------------------------------
// bgi_ctrl
// Query sequencer: cell search, coordinate and grid fetch, four weighted
// terms on a shared multiplier, restoring division, rounding and output.
// ----------------------------------------------------------------------------
module bgi_ctrl
  import bgi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_op,
  input  bgi_sts_t   sts,
  output logic       busy,
  output bgi_cmd_t   cmd
);

  bgi_state_t state_r, state_nxt;
  logic       is_query;

  assign is_query = (in_op == OP_QUERY);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start && is_query) state_nxt = ST_SCAN;
      ST_SCAN:  if (sts.scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_RD_LO;
      ST_RD_LO: state_nxt = ST_RD_HI;
      ST_RD_HI: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_GRD;
      ST_GRD:   state_nxt = ST_M1;
      ST_M1:    state_nxt = ST_M2;
      ST_M2:    state_nxt = ST_M3;
      ST_M3:    state_nxt = ST_ACC;
      ST_ACC:   state_nxt = sts.term_last ? ST_DMUL : ST_GRD;
      ST_DMUL:  state_nxt = ST_DCHK;
      ST_DCHK:  state_nxt = sts.dzero ? ST_FIN : ST_DIV;
      ST_DIV:   if (sts.div_last) state_nxt = ST_RND;
      ST_RND:   state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    cmd.crd = CRD_SCAN;
    unique case (state_r)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.load    = start && !is_query;
        cmd.capture = start && is_query;
      end
      ST_SCAN:  cmd.scan = 1'b1;
      ST_DRAIN: ;
      ST_RD_LO: cmd.crd = CRD_LO;
      ST_RD_HI: begin
        cmd.crd    = CRD_HI;
        cmd.cap_lo = 1'b1;
      end
      ST_DIFF:  cmd.diff = 1'b1;
      ST_GRD:   cmd.grd  = 1'b1;
      ST_M1:    cmd.m1   = 1'b1;
      ST_M2:    cmd.m2   = 1'b1;
      ST_M3:    cmd.m3   = 1'b1;
      ST_ACC:   cmd.acc  = 1'b1;
      ST_DMUL:  cmd.dmul = 1'b1;
      ST_DCHK:  cmd.dchk = 1'b1;
      ST_DIV:   cmd.div  = 1'b1;
      ST_RND:   cmd.rnd  = 1'b1;
      ST_FIN:   cmd.fin  = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/bgi_dpath.sv
// ----------------------------------------------------------------------------
// bgi_dpath
// Coordinate and grid memories, cell index counters, one shared 32x32
// multiplier, wide accumulator, bit-serial divider and output register.
// ----------------------------------------------------------------------------
module bgi_dpath
  import bgi_pkg::*;
#(
  parameter int MAX_X_POINTS = 64,
  parameter int MAX_Y_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  bgi_cmd_t    cmd,
  output bgi_sts_t    sts,
  input  logic [1:0]  in_op,
  input  logic [5:0]  in_x_index,
  input  logic [5:0]  in_y_index,
  input  logic [31:0] in_load_value,
  input  logic [31:0] in_query_x,
  input  logic [31:0] in_query_y,
  input  logic [6:0]  x_used,
  input  logic [6:0]  y_used,
  output logic        out_strobe,
  output logic [31:0] out_interp_value,
  output logic        out_saturated
);

  localparam int XIW = $clog2(MAX_X_POINTS);
  localparam int YIW = $clog2(MAX_Y_POINTS);
  localparam int NXW = $clog2(MAX_X_POINTS + 1);
  localparam int NYW = $clog2(MAX_Y_POINTS + 1);
  localparam int KW  = (XIW > YIW) ? XIW : YIW;
  localparam int GW  = $clog2(MAX_X_POINTS * MAX_Y_POINTS);

  logic [31:0] x_mem [0:MAX_X_POINTS-1];
  logic [31:0] y_mem [0:MAX_Y_POINTS-1];
  logic [31:0] g_mem [0:MAX_X_POINTS*MAX_Y_POINTS-1];

  logic [31:0] x_rd_r, y_rd_r, g_rd_r;
  logic        x_we, y_we, g_we;
  logic [XIW-1:0] x_wa, x_ra;
  logic [YIW-1:0] y_wa, y_ra;
  logic [GW-1:0]  g_wa, g_ra;

  logic signed [31:0] qx_r, qy_r, x1_r, y1_r;
  logic [NXW-1:0] nx_r, nx_clamp;
  logic [NYW-1:0] ny_r, ny_clamp;
  logic [KW-1:0]  k_r;
  logic [XIW-1:0] i_r, ia;
  logic [YIW-1:0] j_r, jb;
  logic           pend_x_r, pend_y_r;
  logic [1:0]     t_r;

  logic [31:0] mp0_r, mp1_r, mq0_r, mq1_r, mdx_r, mdy_r;
  logic        sp0_r, sp1_r, sq0_r, sq1_r, sdx_r, sdy_r;
  logic signed [32:0] dp0, dp1, dq0, dq1, ddx, ddy;

  logic [31:0] mul_a, mul_b, mag_g, mag_p, mag_q;
  logic        sg_p, sg_q;
  logic [63:0] mp_r, plo_r;
  logic [31:0] mhi_r;
  logic        tsign_r;
  logic [95:0] prod;
  logic [ACC_W-1:0] term_ext, acc_r, n_r;
  logic [63:0] rem_r;
  logic [64:0] sh;
  logic        ge;
  logic [DIV_CNT_W-1:0] dc_r;
  logic        dz_r, nneg_r, nz_r, neg_r;

  logic        strobe_r;
  logic [31:0] val_r, val_nxt;
  logic        sat_r, sat_nxt;

  // ---------------- memories
  assign x_we = cmd.load && (in_op == OP_LOAD_X) && (32'(in_x_index) < MAX_X_POINTS);
  assign y_we = cmd.load && (in_op == OP_LOAD_Y) && (32'(in_y_index) < MAX_Y_POINTS);
  assign g_we = cmd.load && (in_op == OP_LOAD_G) && (32'(in_x_index) < MAX_X_POINTS)
                && (32'(in_y_index) < MAX_Y_POINTS);
  assign x_wa = XIW'(in_x_index);
  assign y_wa = YIW'(in_y_index);
  assign g_wa = GW'(32'(in_x_index) * MAX_Y_POINTS + 32'(in_y_index));

  always_comb begin
    case (cmd.crd)
      CRD_LO:  begin x_ra = i_r - XIW'(1); y_ra = j_r - YIW'(1); end
      CRD_HI:  begin x_ra = i_r;           y_ra = j_r;           end
      default: begin x_ra = k_r[XIW-1:0];  y_ra = k_r[YIW-1:0];  end
    endcase
  end

  assign ia   = t_r[0] ? i_r : i_r - XIW'(1);
  assign jb   = t_r[1] ? j_r : j_r - YIW'(1);
  assign g_ra = GW'(32'(ia) * MAX_Y_POINTS + 32'(jb));

  always_ff @(posedge clk) begin
    if (x_we) x_mem[x_wa] <= in_load_value;
    x_rd_r <= x_mem[x_ra];
  end

  always_ff @(posedge clk) begin
    if (y_we) y_mem[y_wa] <= in_load_value;
    y_rd_r <= y_mem[y_ra];
  end

  always_ff @(posedge clk) begin
    if (g_we) g_mem[g_wa] <= in_load_value;
    g_rd_r <= g_mem[g_ra];
  end

  // ---------------- cell search
  assign nx_clamp = (x_used < 7'd2) ? NXW'(2) :
                    ((32'(x_used) > MAX_X_POINTS) ? NXW'(MAX_X_POINTS) : NXW'(x_used));
  assign ny_clamp = (y_used < 7'd2) ? NYW'(2) :
                    ((32'(y_used) > MAX_Y_POINTS) ? NYW'(MAX_Y_POINTS) : NYW'(y_used));

  assign sts.scan_last = (32'(k_r) + 2) >=
                         ((32'(nx_r) > 32'(ny_r)) ? 32'(nx_r) : 32'(ny_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_x_r <= 1'b0;
      pend_y_r <= 1'b0;
    end else begin
      pend_x_r <= cmd.scan && ((32'(k_r) + 1) < 32'(nx_r));
      pend_y_r <= cmd.scan && ((32'(k_r) + 1) < 32'(ny_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qx_r <= in_query_x;
      qy_r <= in_query_y;
      nx_r <= nx_clamp;
      ny_r <= ny_clamp;
      k_r  <= KW'(1);
      i_r  <= XIW'(1);
      j_r  <= YIW'(1);
    end else begin
      if (cmd.scan) k_r <= k_r + KW'(1);
      // count interior coordinates not above the query point
      if (pend_x_r && ($signed(x_rd_r) <= qx_r)) i_r <= i_r + XIW'(1);
      if (pend_y_r && ($signed(y_rd_r) <= qy_r)) j_r <= j_r + YIW'(1);
    end
  end

  // ---------------- cell geometry
  assign dp0 = {x_rd_r[31], x_rd_r} - {qx_r[31], qx_r};
  assign dp1 = {qx_r[31], qx_r} - {x1_r[31], x1_r};
  assign ddx = {x_rd_r[31], x_rd_r} - {x1_r[31], x1_r};
  assign dq0 = {y_rd_r[31], y_rd_r} - {qy_r[31], qy_r};
  assign dq1 = {qy_r[31], qy_r} - {y1_r[31], y1_r};
  assign ddy = {y_rd_r[31], y_rd_r} - {y1_r[31], y1_r};

  always_ff @(posedge clk) begin
    if (cmd.cap_lo) begin
      x1_r <= x_rd_r;
      y1_r <= y_rd_r;
    end
    if (cmd.diff) begin
      mp0_r <= dp0[32] ? 32'(-dp0) : dp0[31:0];
      mp1_r <= dp1[32] ? 32'(-dp1) : dp1[31:0];
      mq0_r <= dq0[32] ? 32'(-dq0) : dq0[31:0];
      mq1_r <= dq1[32] ? 32'(-dq1) : dq1[31:0];
      mdx_r <= ddx[32] ? 32'(-ddx) : ddx[31:0];
      mdy_r <= ddy[32] ? 32'(-ddy) : ddy[31:0];
      sp0_r <= dp0[32];
      sp1_r <= dp1[32];
      sq0_r <= dq0[32];
      sq1_r <= dq1[32];
      sdx_r <= ddx[32];
      sdy_r <= ddy[32];
    end
  end

  // ---------------- shared multiplier and accumulator
  assign mag_g = g_rd_r[31] ? (~g_rd_r + 32'd1) : g_rd_r;
  assign mag_p = t_r[0] ? mp1_r : mp0_r;
  assign sg_p  = t_r[0] ? sp1_r : sp0_r;
  assign mag_q = t_r[1] ? mq1_r : mq0_r;
  assign sg_q  = t_r[1] ? sq1_r : sq0_r;

  always_comb begin
    mul_a = mhi_r;
    mul_b = mag_q;
    if (cmd.m1) begin
      mul_a = mag_g;
      mul_b = mag_p;
    end else if (cmd.m2) begin
      mul_a = mp_r[31:0];
    end else if (cmd.dmul) begin
      mul_a = mdx_r;
      mul_b = mdy_r;
    end
  end

  assign prod     = {mp_r[63:0], 32'd0} + {32'd0, plo_r};
  assign term_ext = tsign_r ? -{2'd0, prod} : {2'd0, prod};

  assign sts.term_last = (t_r == 2'd3);
  assign sts.dzero     = (mp_r == 64'd0);

  always_ff @(posedge clk) begin
    if (cmd.m1 || cmd.m2 || cmd.m3 || cmd.dmul) mp_r <= mul_a * mul_b;
    if (cmd.m1) tsign_r <= g_rd_r[31] ^ sg_p ^ sg_q;
    if (cmd.m2) mhi_r <= mp_r[63:32];
    if (cmd.m3) plo_r <= mp_r;
    if (cmd.capture) begin
      acc_r <= '0;
      t_r   <= 2'd0;
    end else if (cmd.acc) begin
      acc_r <= acc_r + term_ext;
      t_r   <= t_r + 2'd1;
    end
  end

  // ---------------- restoring division, one quotient bit a cycle
  assign sh = {rem_r, n_r[ACC_W-1]};
  assign ge = sh >= {1'b0, mp_r};
  assign sts.div_last = (dc_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.dchk) begin
      n_r    <= acc_r[ACC_W-1] ? -acc_r : acc_r;
      rem_r  <= '0;
      dc_r   <= DIV_CNT_W'(ACC_W - 1);
      dz_r   <= (mp_r == 64'd0);
      nneg_r <= acc_r[ACC_W-1];
      nz_r   <= (acc_r != '0);
      neg_r  <= acc_r[ACC_W-1] ^ sdx_r ^ sdy_r;
    end else if (cmd.div) begin
      rem_r <= ge ? 64'(sh - {1'b0, mp_r}) : sh[63:0];
      n_r   <= {n_r[ACC_W-2:0], ge};
      dc_r  <= dc_r - DIV_CNT_W'(1);
    end else if (cmd.rnd) begin
      // round half away from zero on the magnitude
      n_r <= n_r + ACC_W'({rem_r, 1'b0} >= {1'b0, mp_r});
    end
  end

  // ---------------- saturation and output
  always_comb begin
    sat_nxt = 1'b0;
    if (dz_r) begin
      sat_nxt = 1'b1;
      val_nxt = !nz_r ? 32'd0 : (nneg_r ? VAL_MIN : VAL_MAX);
    end else if (neg_r) begin
      val_nxt = ~n_r[31:0] + 32'd1;
      if (n_r > ACC_W'(VAL_MIN)) begin
        sat_nxt = 1'b1;
        val_nxt = VAL_MIN;
      end
    end else begin
      val_nxt = n_r[31:0];
      if (n_r > ACC_W'(VAL_MAX)) begin
        sat_nxt = 1'b1;
        val_nxt = VAL_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      val_r <= val_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_interp_value = val_r;
  assign out_saturated    = sat_r;

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |=> (rem_r < mp_r))
    else $error("division remainder not below divisor");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result strobe held longer than one cycle");

  a_cell_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.crd == CRD_LO) |-> ((i_r != '0) && (32'(i_r) < 32'(nx_r))
                             && (j_r != '0) && (32'(j_r) < 32'(ny_r))))
    else $error("cell index outside the grid");
`endif

endmodule

// File: hdl/bilinear_grid_interpolator_unit.sv
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator_unit
// Bilinear interpolation over a non-uniform grid in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are taken at a rising edge with start high and busy low.
//   in_op selects a load of an x coordinate, a y coordinate or a grid value
//   (written at that edge, busy never rises, no result) or a
//   query at (in_query_x, in_query_y).
//   A query raises busy and returns one result word: out_strobe is high for
//   exactly one cycle with out_interp_value and out_saturated. The receiver
//   cannot stall; the word must be taken in that cycle.
//   A query runs the cell search over the interior coordinates, at least one
//   step, then four products on one shared 32x32 multiplier and the
//   bit-serial divider, which takes most of the query time. A zero-area
//   cell skips divider and rounding. The next word is taken in the strobe
//   cycle; loads go one a cycle.
//   The APB port sets x_points_used (address 0) and y_points_used
//   (address 4); write it only while busy is low. Reset clears the controller
//   and restores both point counts to 64; memories must be loaded first.
// ----------------------------------------------------------------------------
module bilinear_grid_interpolator_unit
  import bgi_pkg::*;
#(
  parameter int MAX_X_POINTS = 64,
  parameter int MAX_Y_POINTS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [5:0]            in_x_index,
  input  logic [5:0]            in_y_index,
  input  logic [31:0]           in_load_value,
  input  logic [31:0]           in_query_x,
  input  logic [31:0]           in_query_y,
  output logic                  out_strobe,
  output logic [31:0]           out_interp_value,
  output logic                  out_saturated,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  bgi_cmd_t   cmd;
  bgi_sts_t   sts;
  logic [6:0] x_used, y_used;

  bgi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .x_used  (x_used),
    .y_used  (y_used)
  );

  bgi_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  bgi_dpath #(
    .MAX_X_POINTS (MAX_X_POINTS),
    .MAX_Y_POINTS (MAX_Y_POINTS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_x_index       (in_x_index),
    .in_y_index       (in_y_index),
    .in_load_value    (in_load_value),
    .in_query_x       (in_query_x),
    .in_query_y       (in_query_y),
    .x_used           (x_used),
    .y_used           (y_used),
    .out_strobe       (out_strobe),
    .out_interp_value (out_interp_value),
    .out_saturated    (out_saturated)
  );

endmodule
